[rtl/spq_pkg.sv]
package spq_pkg;

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int PRI_IN_W   = 8;
    localparam int ERR_W      = 2;

    // operation codes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    // result error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } spq_err_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } spq_ctrl_t;

endpackage

[rtl/spq_cell.sv]
module spq_cell #(
    parameter int PRI_W = 8
) (
    input  logic                         clk,
    input  spq_pkg::spq_ctrl_t           ctrl,
    input  logic                         occupied,
    input  logic                         prev_after,
    input  logic [spq_pkg::VALUE_W-1:0]  prev_value,
    input  logic [PRI_W-1:0]             prev_prio,
    input  logic [spq_pkg::VALUE_W-1:0]  next_value,
    input  logic [PRI_W-1:0]             next_prio,
    input  logic [spq_pkg::VALUE_W-1:0]  new_value,
    input  logic [PRI_W-1:0]             new_prio,
    output logic [spq_pkg::VALUE_W-1:0]  value,
    output logic [PRI_W-1:0]             prio,
    output logic                         after
);
    import spq_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [PRI_W-1:0]   prio_reg;
    logic [PRI_W-1:0]   prio_next;

    // new word goes behind this entry when this entry is stored and the new word is not more urgent
    assign after = occupied && (prio_reg <= new_prio);

    // keep, take the new word, shift from the left, or shift from the right
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.push_en && !after)
        begin
            if (prev_after)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = prev_value;
                prio_next  = prev_prio;
            end
        end
        else if (ctrl.pop_en)
        begin
            value_next = next_value;
            prio_next  = next_prio;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

[rtl/spq_out_buf.sv]
module spq_out_buf #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    output logic             dout_valid,
    input  logic             dout_stall,
    output logic [WIDTH-1:0] dout
);
    logic             valid0_reg;
    logic             valid0_next;
    logic             valid1_reg;
    logic             valid1_next;
    logic [WIDTH-1:0] data0_reg;
    logic [WIDTH-1:0] data0_next;
    logic [WIDTH-1:0] data1_reg;
    logic [WIDTH-1:0] data1_next;
    logic             take;

    assign take = valid0_reg && !dout_stall;

    // two-entry queue: head word in slot 0, waiting word in slot 1
    always_comb
    begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        if (take)
        begin
            if (valid1_reg)
            begin
                data0_next  = data1_reg;
                valid0_next = 1'b1;
                if (push)
                begin
                    data1_next = din;
                end
                else
                begin
                    valid1_next = 1'b0;
                end
            end
            else
            begin
                data0_next  = din;
                valid0_next = push;
            end
        end
        else if (push)
        begin
            if (valid0_reg)
            begin
                data1_next  = din;
                valid1_next = 1'b1;
            end
            else
            begin
                data0_next  = din;
                valid0_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

    assign full       = valid1_reg;
    assign dout_valid = valid0_reg;
    assign dout       = data0_reg;

endmodule

[rtl/stable_priority_queue.sv]
// Stable sorted priority queue of QUEUE_DEPTH entries held in a row of cells,
// lowest priority number at the head, equal priorities in arrival order. Each
// word is a push or a pop and yields one result word with the head after the
// operation, the entry count and an error code. One word is accepted every
// cycle while item_stall is low: all cells compare against the pushed priority
// and shift left or right in the same cycle, and the result is registered in
// a two-entry result buffer that lets input continue while a result waits;
// item_stall rises only when both entries are held. No clearing pass after reset.
module stable_priority_queue #(
    parameter int  QUEUE_DEPTH   = 16,
    parameter int  PRIORITY_BITS = 8,
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          operation,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic [spq_pkg::PRI_IN_W-1:0]  item_priority,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
    output logic                          head_valid,
    output logic [CNT_W-1:0]              entry_count,
    output logic [spq_pkg::ERR_W-1:0]     error_code
);
    import spq_pkg::*;

    localparam int RES_W = VALUE_W + 1 + CNT_W + ERR_W;

    logic                     accept;
    logic                     buf_full;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     is_full;
    logic                     is_empty;
    logic [PRIORITY_BITS-1:0] pri_in;
    spq_ctrl_t                ctrl;

    logic [VALUE_W-1:0]       cell_value [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
    logic                     cell_after [QUEUE_DEPTH];
    logic                     cell_occ   [QUEUE_DEPTH];

    logic [VALUE_W-1:0]       res_value;
    logic                     res_valid;
    spq_err_t                 res_err;
    logic [RES_W-1:0]         res_word;
    logic [RES_W-1:0]         buf_word;

    assign accept     = item_valid && !buf_full;
    assign item_stall = buf_full;
    assign is_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty   = (count_reg == '0);

    // keep the low priority bits, zero-extend when the cells are wider
    always_comb
    begin
        pri_in = '0;
        for (int b = 0; b < PRIORITY_BITS && b < PRI_IN_W; b++)
        begin
            pri_in[b] = item_priority[b];
        end
    end

    // command to the cell row
    always_comb
    begin
        ctrl.push_en = accept && (operation == OP_PUSH) && !is_full;
        ctrl.pop_en  = accept && (operation == OP_POP) && !is_empty;
    end

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                     left_after;
        logic [VALUE_W-1:0]       left_value;
        logic [PRIORITY_BITS-1:0] left_prio;
        logic [VALUE_W-1:0]       right_value;
        logic [PRIORITY_BITS-1:0] right_prio;

        assign cell_occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_after = 1'b1;
            assign left_value = item_value;
            assign left_prio  = pri_in;
        end
        else
        begin : g_mid
            assign left_after = cell_after[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell #(
            .PRI_W (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .prev_after (left_after),
            .prev_value (left_value),
            .prev_prio  (left_prio),
            .next_value (right_value),
            .next_prio  (right_prio),
            .new_value  (item_value),
            .new_prio   (pri_in),
            .value      (cell_value[i]),
            .prio       (cell_prio[i]),
            .after      (cell_after[i])
        );
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // head after the operation
    always_comb
    begin
        res_value = '0;
        res_valid = 1'b0;
        res_err   = ERR_OK;
        if (operation == OP_PUSH)
        begin
            res_valid = 1'b1;
            if (is_full)
            begin
                res_err   = ERR_FULL;
                res_value = cell_value[0];
            end
            else if (cell_after[0])
            begin
                res_value = cell_value[0];
            end
            else
            begin
                res_value = item_value;
            end
        end
        else if (is_empty)
        begin
            res_err = ERR_EMPTY;
        end
        else if (count_reg > CNT_W'(1))
        begin
            res_valid = 1'b1;
            res_value = cell_value[1];
        end
    end

    assign res_word = {res_value, res_valid, count_next, res_err};

    // result buffer
    spq_out_buf #(
        .WIDTH (RES_W)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .din        (res_word),
        .full       (buf_full),
        .dout_valid (result_valid),
        .dout_stall (result_stall),
        .dout       (buf_word)
    );

    assign head_value  = buf_word[RES_W-1 -: VALUE_W];
    assign head_valid  = buf_word[CNT_W + ERR_W];
    assign entry_count = buf_word[ERR_W +: CNT_W];
    assign error_code  = buf_word[ERR_W-1:0];

endmodule

[rtl/spq_checker.sv]
module spq_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [spq_pkg::VALUE_W-1:0]   head_value,
    input  logic                          head_valid,
    input  logic [CNT_W-1:0]              entry_count,
    input  logic [spq_pkg::ERR_W-1:0]     error_code
);
    import spq_pkg::*;

    // head flag matches the count
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (head_valid == (entry_count != '0)))
        else $error("head_valid disagrees with entry_count");

    // empty queue shows a zero head
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !head_valid) |-> (head_value == '0))
        else $error("empty queue with nonzero head_value");

    // dropped push only when full
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error_code == ERR_FULL)
            |-> (entry_count == CNT_W'(QUEUE_DEPTH) && head_valid))
        else $error("full error without a full queue");

    // pop error only on an empty queue
    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error_code == ERR_EMPTY) |-> (entry_count == '0))
        else $error("empty error with entries stored");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall)
            |=> (result_valid && $stable(head_value) && $stable(entry_count)
                 && $stable(error_code)))
        else $error("stalled result changed");

endmodule

bind stable_priority_queue spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head_value   (head_value),
    .head_valid   (head_valid),
    .entry_count  (entry_count),
    .error_code   (error_code)
);

[bench/stable_priority_queue_test.sv]
module stable_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int RAND_WORDS = 700;

    // one expected result word
    typedef struct {
        logic signed [VALUE_W-1:0] head_value;
        logic                      head_valid;
        logic [CNT_W-1:0]          entry_count;
        spq_err_t                  error_code;
    } queue_status_t;

    // sorted queue model plus the list of status words still owed by the block
    class queue_scoreboard;
        logic [VALUE_W-1:0]  slot_val [DEPTH];
        logic [PRI_IN_W-1:0] slot_pri [DEPTH];
        int unsigned         held;
        queue_status_t       status_q [$];
        int unsigned         fail_count;

        function new();
            held = 0;
            fail_count = 0;
        endfunction

        // print one mismatch line, keep the log bounded on a broken block
        task report(string what);
            if (fail_count < 200)
            begin
                $display("%0t ns  mismatch: %s", $time, what);
            end
            fail_count++;
        endtask

        // apply an accepted input word and queue the status it must produce
        function void note_input(spq_op_t op, logic [VALUE_W-1:0] val,
                                 logic [PRI_IN_W-1:0] pri);
            int unsigned   pos;
            int unsigned   k;
            queue_status_t st;
            st.error_code = ERR_OK;
            if (op == OP_PUSH)
            begin
                if (held >= DEPTH)
                begin
                    st.error_code = ERR_FULL;
                end
                else
                begin
                    // insert behind every entry of equal or more urgent priority
                    pos = 0;
                    while (pos < held && slot_pri[pos] <= pri)
                        pos++;
                    for (k = held; k > pos; k--)
                    begin
                        slot_val[k] = slot_val[k-1];
                        slot_pri[k] = slot_pri[k-1];
                    end
                    slot_val[pos] = val;
                    slot_pri[pos] = pri;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    st.error_code = ERR_EMPTY;
                end
                else
                begin
                    for (k = 1; k < held; k++)
                    begin
                        slot_val[k-1] = slot_val[k];
                        slot_pri[k-1] = slot_pri[k];
                    end
                    held--;
                end
            end
            st.head_valid  = (held > 0);
            st.head_value  = (held > 0) ? slot_val[0] : '0;
            st.entry_count = held[CNT_W-1:0];
            status_q.push_back(st);
        endfunction

        // compare a result word with the oldest expected status
        task check_result(logic signed [VALUE_W-1:0] hv, logic hok,
                          logic [CNT_W-1:0] cnt, logic [ERR_W-1:0] err);
            queue_status_t st;
            if (status_q.size() == 0)
            begin
                report($sformatf("unexpected result word head=%0d valid=%0b count=%0d err=%0d",
                                 hv, hok, cnt, err));
            end
            else
            begin
                st = status_q.pop_front();
                if (hv !== st.head_value)
                    report($sformatf("head_value got %0d want %0d", hv, st.head_value));
                if (hok !== st.head_valid)
                    report($sformatf("head_valid got %0b want %0b", hok, st.head_valid));
                if (cnt !== st.entry_count)
                    report($sformatf("entry_count got %0d want %0d", cnt, st.entry_count));
                if (err !== st.error_code)
                    report($sformatf("error_code got %0d want %0d", err, st.error_code));
            end
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    logic                       operation;
    logic signed [VALUE_W-1:0]  item_value;
    logic [PRI_IN_W-1:0]        item_priority;
    logic                       result_valid;
    logic                       result_stall;
    logic signed [VALUE_W-1:0]  head_value;
    logic                       head_valid;
    logic [CNT_W-1:0]           entry_count;
    logic [ERR_W-1:0]           error_code;

    queue_scoreboard sb = new();
    bit              calm;

    stable_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .head_value    (head_value),
        .head_valid    (head_valid),
        .entry_count   (entry_count),
        .error_code    (error_code)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // idle length: mostly none or short, now and then long, none in calm phases
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one input word and hold it until accepted
    task automatic send_word(spq_op_t op, logic [VALUE_W-1:0] val,
                             logic [PRI_IN_W-1:0] pri);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        operation     <= op;
        item_value    <= val;
        item_priority <= pri;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // hold input low until every owed result word is back
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.status_q.size() != 0)
            @(posedge clk);
    endtask

    // extremes, ties, fill to full, push on full, pop on empty
    task automatic run_directed();
        logic [VALUE_W-1:0]  dv [8];
        logic [PRI_IN_W-1:0] dp [8];
        int i;
        dv = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE};
        dp = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h7F};
        send_word(OP_POP, 32'hFFFF_FFFF, 8'hFF);
        for (i = 0; i < 8; i++)
            send_word(OP_PUSH, dv[i], dp[i]);
        for (i = 0; i < 8; i++)
            send_word(OP_PUSH, 32'h1000_0000 + i, 8'(i % 3) * 8'h55);
        send_word(OP_PUSH, 32'h1234_5678, 8'h00);
        for (i = 0; i < 4; i++)
            send_word(OP_POP, $urandom, 8'($urandom));
    endtask

    // random words in phases that swing the queue between empty and full
    task automatic run_random();
        int n;
        int push_pct;
        int pri_mode;
        logic [PRI_IN_W-1:0] pri;
        push_pct = 50;
        for (n = 0; n < RAND_WORDS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n % 200 == 199)
                drain_results();
            pri_mode = $urandom_range(0, 9);
            if (pri_mode < 4)
                pri = 8'($urandom_range(0, 3));
            else if (pri_mode == 4)
                pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            else
                pri = 8'($urandom);
            if ($urandom_range(0, 99) < push_pct)
                send_word(OP_PUSH, $urandom, pri);
            else
                send_word(OP_POP, $urandom, pri);
        end
        calm = 1'b0;
    endtask

    // receiver stall pattern
    initial
    begin
        int g;
        result_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            g = idle_cycles();
            if (g > 0)
            begin
                result_stall <= 1'b1;
                repeat (g) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(head_value, head_valid, entry_count, error_code);
            if (item_valid && !item_stall)
                sb.note_input(spq_op_t'(operation), item_value, item_priority);
        end
    end

    // main sequence
    initial
    begin
        calm          = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        operation     = OP_PUSH;
        item_value    = '0;
        item_priority = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.status_q.size() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.status_q.size()));
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
